@@ hdl/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int SFR_BYTE_W   = 8;
	localparam int SFR_OFFS_W   = 16;
	localparam int SFR_TIME_W   = 16;
	localparam int SFR_DELTA_W  = 15;
	localparam int SFR_STRAT_W  = 2;
	localparam int SFR_CFG_W    = 16;
	localparam int SFR_CIDX_W   = 2;
	localparam int SFR_QUEUE_DEPTH = 2;

	localparam logic [SFR_CIDX_W-1:0] REG_HEADER  = 2'd0;
	localparam logic [SFR_CIDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [SFR_CIDX_W-1:0] REG_DELTA   = 2'd2;
	localparam logic [SFR_CIDX_W-1:0] REG_WIDTH   = 2'd3;

	localparam logic [SFR_STRAT_W-1:0] ST_NONE     = 2'd0;
	localparam logic [SFR_STRAT_W-1:0] ST_LEFT     = 2'd1;
	localparam logic [SFR_STRAT_W-1:0] ST_RIGHT    = 2'd2;
	localparam logic [SFR_STRAT_W-1:0] ST_STRAIGHT = 2'd3;

	localparam logic [SFR_BYTE_W-1:0]  HEADER_RESET  = 8'd165;
	localparam logic [SFR_TIME_W-1:0]  TIMEOUT_RESET = 16'd500;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_FRAME,
		OP_TICK
	} sfr_op_kind_t;

	typedef struct packed {
		sfr_op_kind_t                  kind;
		logic [SFR_STRAT_W-1:0]        strategy;
		logic signed [SFR_OFFS_W-1:0]  live_offset;
	} sfr_op_t;

	typedef struct packed {
		logic [SFR_BYTE_W-1:0]   header_byte;
		logic [SFR_TIME_W-1:0]   timeout_ms;
		logic [SFR_DELTA_W-1:0]  offset_delta;
		logic [SFR_DELTA_W-1:0]  track_width;
	} sfr_cfg_t;

endpackage

@@ hdl/sfr_in_if.sv @@
`timescale 1ns / 1ps

interface sfr_in_if import sfr_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         command;
	logic [SFR_BYTE_W-1:0]        rx_byte;
	logic signed [SFR_OFFS_W-1:0] live_offset;

	modport source(output valid, command, rx_byte, live_offset, input ready);
	modport sink(input valid, command, rx_byte, live_offset, output ready);
endinterface

@@ hdl/sfr_out_if.sv @@
`timescale 1ns / 1ps

interface sfr_out_if import sfr_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic                         frame_ok;
	logic [SFR_STRAT_W-1:0]       strategy;
	logic                         offset_write;
	logic signed [SFR_OFFS_W-1:0] offset_value;
	logic                         timed_out;

	modport source(output valid, frame_ok, strategy, offset_write, offset_value, timed_out,
		input ready);
	modport sink(input valid, frame_ok, strategy, offset_write, offset_value, timed_out,
		output ready);
endinterface

@@ hdl/sfr_front.sv @@
`timescale 1ns / 1ps

module sfr_front import sfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfr_in_if.sink    in_ch,
	input  logic [SFR_BYTE_W-1:0] header_byte,
	output logic      push,
	output sfr_op_t   push_op,
	input  logic      push_ready
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_STRATEGY,
		PH_CHECKSUM
	} phase_t;

	phase_t                phase_q;
	logic [SFR_BYTE_W-1:0] held_q;
	logic                  accept;
	logic                  frame_good;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid && push_ready;
	assign push        = accept;

	assign frame_good = (in_ch.rx_byte == (header_byte ^ held_q)) &&
		(held_q[SFR_BYTE_W-1:SFR_STRAT_W] == '0);

	always_comb begin
		push_op.live_offset = in_ch.live_offset;
		push_op.strategy    = held_q[SFR_STRAT_W-1:0];
		if (in_ch.command) begin
			push_op.kind = OP_TICK;
		end else if (phase_q == PH_CHECKSUM && frame_good) begin
			push_op.kind = OP_FRAME;
		end else begin
			push_op.kind = OP_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			held_q  <= '0;
		end else if (accept && !in_ch.command) begin
			case (phase_q)
				PH_STRATEGY: begin
					held_q  <= in_ch.rx_byte;
					phase_q <= PH_CHECKSUM;
				end
				PH_CHECKSUM: begin
					phase_q <= PH_HEADER;
				end
				default: begin
					phase_q <= (in_ch.rx_byte == header_byte) ? PH_STRATEGY : PH_HEADER;
				end
			endcase
		end
	end

endmodule

@@ hdl/sfr_queue.sv @@
`timescale 1ns / 1ps

module sfr_queue import sfr_pkg::*; #(
	parameter int DEPTH = SFR_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sfr_op_t push_op,
	output logic    push_ready,
	output logic    pop_valid,
	output sfr_op_t pop_op,
	input  logic    pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	sfr_op_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/sfr_back.sv @@
`timescale 1ns / 1ps

module sfr_back import sfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sfr_cfg_t cfg,
	input  logic     op_valid,
	input  sfr_op_t  op,
	output logic     pop,
	sfr_out_if.source out_ch
);

	localparam int EXT_W = SFR_OFFS_W + 2;
	localparam logic signed [EXT_W-1:0] SAT_MIN = -(EXT_W'(1) <<< (SFR_OFFS_W - 1));
	localparam logic signed [EXT_W-1:0] SAT_MAX = (EXT_W'(1) <<< (SFR_OFFS_W - 1)) - 1;
	localparam logic [SFR_TIME_W-1:0]   CNT_MAX = '1;

	logic [SFR_STRAT_W-1:0]        cur_q;
	logic [SFR_STRAT_W-1:0]        applied_q;
	logic signed [SFR_OFFS_W-1:0]  restore_q;
	logic                          saved_q;
	logic [SFR_TIME_W-1:0]         silence_q;

	logic                          out_valid_q;
	logic                          frame_ok_q;
	logic [SFR_STRAT_W-1:0]        strategy_q;
	logic                          offset_write_q;
	logic signed [SFR_OFFS_W-1:0]  offset_value_q;
	logic                          timed_out_q;

	logic                          capture;
	logic signed [SFR_OFFS_W-1:0]  base;
	logic signed [EXT_W-1:0]       base_x;
	logic signed [EXT_W-1:0]       delta_x;
	logic signed [EXT_W-1:0]       width_x;
	logic signed [EXT_W-1:0]       nv;
	logic signed [EXT_W-1:0]       nv_clamped;
	logic [SFR_TIME_W-1:0]         silence_inc;
	logic                          expire;

	assign pop = op_valid && (!out_valid_q || out_ch.ready);

	assign capture = (applied_q == ST_NONE) && (op.strategy != ST_NONE);
	assign base    = capture ? op.live_offset : restore_q;
	assign base_x  = EXT_W'(base);
	assign delta_x = $signed({2'b00, 1'b0, cfg.offset_delta});
	assign width_x = $signed({2'b00, 1'b0, cfg.track_width});

	always_comb begin
		case (op.strategy)
			ST_LEFT:  nv = base_x - delta_x;
			ST_RIGHT: nv = base_x + delta_x;
			default:  nv = base_x;
		endcase
		if (cfg.track_width != '0) begin
			if (nv < 0) begin
				nv_clamped = '0;
			end else if (nv > width_x) begin
				nv_clamped = width_x;
			end else begin
				nv_clamped = nv;
			end
		end else begin
			if (nv < SAT_MIN) begin
				nv_clamped = SAT_MIN;
			end else if (nv > SAT_MAX) begin
				nv_clamped = SAT_MAX;
			end else begin
				nv_clamped = nv;
			end
		end
	end

	assign silence_inc = (silence_q != CNT_MAX) ? silence_q + 1'b1 : silence_q;
	assign expire      = (silence_inc > cfg.timeout_ms) && (cur_q != ST_NONE);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.frame_ok     = frame_ok_q;
	assign out_ch.strategy     = strategy_q;
	assign out_ch.offset_write = offset_write_q;
	assign out_ch.offset_value = offset_value_q;
	assign out_ch.timed_out    = timed_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			frame_ok_q     <= 1'b0;
			strategy_q     <= ST_NONE;
			offset_write_q <= 1'b0;
			offset_value_q <= '0;
			timed_out_q    <= 1'b0;
			cur_q          <= ST_NONE;
			applied_q      <= ST_NONE;
			restore_q      <= '0;
			saved_q        <= 1'b0;
			silence_q      <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q    <= 1'b1;
				frame_ok_q     <= 1'b0;
				strategy_q     <= cur_q;
				offset_write_q <= 1'b0;
				offset_value_q <= '0;
				timed_out_q    <= 1'b0;
				case (op.kind)
					OP_FRAME: begin
						frame_ok_q <= 1'b1;
						strategy_q <= op.strategy;
						cur_q      <= op.strategy;
						silence_q  <= '0;
						if (op.strategy != applied_q) begin
							if (capture) begin
								restore_q <= op.live_offset;
								saved_q   <= 1'b1;
							end
							if (op.strategy == ST_NONE) begin
								saved_q <= 1'b0;
							end
							applied_q      <= op.strategy;
							offset_write_q <= 1'b1;
							offset_value_q <= nv_clamped[SFR_OFFS_W-1:0];
						end
					end
					OP_TICK: begin
						silence_q <= silence_inc;
						if (expire) begin
							cur_q       <= ST_NONE;
							strategy_q  <= ST_NONE;
							timed_out_q <= 1'b1;
							if (saved_q) begin
								offset_write_q <= 1'b1;
								offset_value_q <= restore_q;
								applied_q      <= ST_NONE;
								saved_q        <= 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_saved_tracks_applied: assert property (@(posedge clk) disable iff (!arst_n)
		saved_q == (applied_q != ST_NONE))
		else $error("restore flag out of step with applied strategy");

	a_timeout_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && timed_out_q |-> (strategy_q == ST_NONE) && !frame_ok_q)
		else $error("timeout word with active strategy or frame flag");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !offset_write_q |-> offset_value_q == '0)
		else $error("offset value nonzero without write");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(offset_value_q))
		else $error("stalled result word changed");
`endif

endmodule

@@ hdl/strategy_frame_receiver.sv @@
`timescale 1ns / 1ps

// channel   dir  words
// in_ch     in   command, rx_byte, live_offset
// out_ch    out  frame_ok, strategy, offset_write, offset_value, timed_out
// cfg_*     in   write enable, register index, write data
//
// one word per cycle sustained while out_ch.ready holds; a taken word is offered as a result
// after the parser puts it into a queue slot and it is then popped into the result register
// the queue holds QUEUE_DEPTH words, so the input keeps flowing while a result waits
// reset is asynchronous: registers take their reset values, queue and output empty
// an output stall backs up the queue and then drops in_ch.ready

module strategy_frame_receiver import sfr_pkg::*; #(
	parameter int QUEUE_DEPTH = SFR_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sfr_in_if.sink                in_ch,
	sfr_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [SFR_CIDX_W-1:0] cfg_index,
	input  logic [SFR_CFG_W-1:0]  cfg_data
);

	sfr_cfg_t cfg_q;
	logic     push;
	sfr_op_t  push_op;
	logic     push_ready;
	logic     op_valid;
	sfr_op_t  op;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_byte  <= HEADER_RESET;
			cfg_q.timeout_ms   <= TIMEOUT_RESET;
			cfg_q.offset_delta <= '0;
			cfg_q.track_width  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:  cfg_q.header_byte  <= cfg_data[SFR_BYTE_W-1:0];
				REG_TIMEOUT: cfg_q.timeout_ms   <= cfg_data[SFR_TIME_W-1:0];
				REG_DELTA:   cfg_q.offset_delta <= cfg_data[SFR_DELTA_W-1:0];
				REG_WIDTH:   cfg_q.track_width  <= cfg_data[SFR_DELTA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.header_byte(cfg_q.header_byte),
		.push       (push),
		.push_op    (push_op),
		.push_ready (push_ready)
	);

	sfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.push_ready(push_ready),
		.pop_valid (op_valid),
		.pop_op    (op),
		.pop       (pop)
	);

	sfr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.op_valid(op_valid),
		.op      (op),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

@@ tb/sfr_checker.sv @@
`timescale 1ns / 1ps

package sfr_check_pkg;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

endpackage

module sfr_checker import sfr_pkg::*, sfr_check_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	sfr_in_if                     in_ch,
	sfr_out_if                    out_ch,
	input  logic                  cfg_we,
	input  logic [SFR_CIDX_W-1:0] cfg_index,
	input  logic [SFR_CFG_W-1:0]  cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    frames_ok,
	output int                    offset_writes,
	output int                    timeouts
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_STRATEGY,
		PH_CHECKSUM
	} parse_phase_t;

	typedef struct packed {
		logic                         frame_ok;
		logic [SFR_STRAT_W-1:0]       strategy;
		logic                         offset_write;
		logic signed [SFR_OFFS_W-1:0] offset_value;
		logic                         timed_out;
	} frame_result_t;

	logic [SFR_BYTE_W-1:0]        hdr_q;
	logic [SFR_TIME_W-1:0]        tmo_q;
	logic [SFR_DELTA_W-1:0]       delta_q;
	logic [SFR_DELTA_W-1:0]       width_q;

	parse_phase_t                 phase_q;
	logic [SFR_BYTE_W-1:0]        held_q;
	logic [SFR_STRAT_W-1:0]       cur_q;
	logic [SFR_STRAT_W-1:0]       applied_q;
	logic signed [SFR_OFFS_W-1:0] restore_q;
	logic                         saved_q;
	logic [SFR_TIME_W-1:0]        silence_q;

	frame_result_t                results_q[$];
	frame_result_t                want;

	function automatic frame_result_t step_receiver(input logic cmd,
			input logic [SFR_BYTE_W-1:0] b, input logic signed [SFR_OFFS_W-1:0] live);
		frame_result_t r;
		int nv;
		r = '0;
		if (cmd == CMD_BYTE) begin
			case (phase_q)
				PH_STRATEGY: begin
					held_q = b;
					phase_q = PH_CHECKSUM;
				end
				PH_CHECKSUM: begin
					phase_q = PH_HEADER;
					if (b == (hdr_q ^ held_q) && held_q <= {6'b0, ST_STRAIGHT}) begin
						r.frame_ok = 1'b1;
						cur_q = held_q[SFR_STRAT_W-1:0];
						silence_q = '0;
						if (held_q[SFR_STRAT_W-1:0] != applied_q) begin
							// leaving none captures the live offset for later restore
							if (applied_q == ST_NONE) begin
								restore_q = live;
								saved_q = 1'b1;
							end
							nv = int'(restore_q);
							case (held_q[SFR_STRAT_W-1:0])
								ST_LEFT:  nv = nv - int'(delta_q);
								ST_RIGHT: nv = nv + int'(delta_q);
								ST_NONE:  saved_q = 1'b0;
								default:  ;
							endcase
							if (width_q != '0) begin
								if (nv < 0) nv = 0;
								if (nv > int'(width_q)) nv = int'(width_q);
							end else begin
								if (nv < -32768) nv = -32768;
								if (nv > 32767) nv = 32767;
							end
							applied_q = held_q[SFR_STRAT_W-1:0];
							r.offset_write = 1'b1;
							r.offset_value = nv[SFR_OFFS_W-1:0];
						end
					end
				end
				default: phase_q = (b == hdr_q) ? PH_STRATEGY : PH_HEADER;
			endcase
		end else begin
			if (silence_q != '1) silence_q = silence_q + 1'b1;
			if (silence_q > tmo_q && cur_q != ST_NONE) begin
				cur_q = ST_NONE;
				r.timed_out = 1'b1;
				if (saved_q) begin
					r.offset_write = 1'b1;
					r.offset_value = restore_q;
					applied_q = ST_NONE;
					saved_q = 1'b0;
				end
			end
		end
		r.strategy = cur_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q = HEADER_RESET;
			tmo_q = TIMEOUT_RESET;
			delta_q = '0;
			width_q = '0;
			phase_q = PH_HEADER;
			held_q = '0;
			cur_q = ST_NONE;
			applied_q = ST_NONE;
			restore_q = '0;
			saved_q = 1'b0;
			silence_q = '0;
			results_q.delete();
			errors = 0;
			frames_ok = 0;
			offset_writes = 0;
			timeouts = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HEADER:  hdr_q = cfg_data[SFR_BYTE_W-1:0];
					REG_TIMEOUT: tmo_q = cfg_data[SFR_TIME_W-1:0];
					REG_DELTA:   delta_q = cfg_data[SFR_DELTA_W-1:0];
					REG_WIDTH:   width_q = cfg_data[SFR_DELTA_W-1:0];
					default:     ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (results_q.size() == 0) begin
					$display("%t: unexpected word, expected none, got ok=%0b st=%0d wr=%0b val=%0d to=%0b",
						$time, out_ch.frame_ok, out_ch.strategy, out_ch.offset_write,
						out_ch.offset_value, out_ch.timed_out);
					errors++;
				end else begin
					want = results_q.pop_front();
					check_field("frame_ok", want.frame_ok, out_ch.frame_ok);
					check_field("strategy", want.strategy, out_ch.strategy);
					check_field("offset_write", want.offset_write, out_ch.offset_write);
					check_field("offset_value", want.offset_value, out_ch.offset_value);
					check_field("timed_out", want.timed_out, out_ch.timed_out);
					frames_ok += want.frame_ok;
					offset_writes += want.offset_write;
					timeouts += want.timed_out;
				end
			end
			if (in_ch.valid && in_ch.ready)
				results_q.push_back(step_receiver(in_ch.command, in_ch.rx_byte,
					in_ch.live_offset));
		end
		pending = results_q.size();
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

	import sfr_pkg::*;
	import sfr_check_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_WORDS = 268;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [SFR_CIDX_W-1:0] cfg_index;
	logic [SFR_CFG_W-1:0]  cfg_data;

	int errors;
	int pending;
	int frames_ok;
	int offset_writes;
	int timeouts;

	bit idling = 1'b0;
	bit hold_req = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int words_sent = 0;
	int frames_sent = 0;
	int ticks_sent = 0;
	int strays_sent = 0;
	logic [SFR_BYTE_W-1:0] hdr_now = HEADER_RESET;

	sfr_in_if in_ch();
	sfr_out_if out_ch();

	strategy_frame_receiver u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sfr_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.frames_ok     (frames_ok),
		.offset_writes (offset_writes),
		.timeouts      (timeouts)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output side: random stalls while idling, plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready = 1'b0;
			stall_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			stall_left = 60;
			out_ch.ready = 1'b0;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [SFR_OFFS_W-1:0] live_rnd();
		case ($urandom_range(0, 7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'($urandom_range(0, 63));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push_word(input logic cmd, input logic [SFR_BYTE_W-1:0] b,
			input logic signed [SFR_OFFS_W-1:0] live);
		int gap;
		if (idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.command = cmd;
		in_ch.rx_byte = b;
		in_ch.live_offset = live;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		words_sent++;
		if (cmd == CMD_TICK) ticks_sent++;
	endtask

	task automatic send_frame(input logic [SFR_BYTE_W-1:0] strat, input bit good,
			input logic signed [SFR_OFFS_W-1:0] live);
		logic [SFR_BYTE_W-1:0] sum;
		sum = hdr_now ^ strat;
		if (!good) sum = sum ^ 8'($urandom_range(1, 255));
		push_word(CMD_BYTE, hdr_now, live_rnd());
		push_word(CMD_BYTE, strat, live_rnd());
		push_word(CMD_BYTE, sum, live);
		frames_sent++;
	endtask

	task automatic settle();
		in_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [SFR_CIDX_W-1:0] idx, input logic [SFR_CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(input logic [SFR_BYTE_W-1:0] hdr, input logic [SFR_TIME_W-1:0] tmo,
			input logic [SFR_DELTA_W-1:0] delta, input logic [SFR_DELTA_W-1:0] width);
		settle();
		write_reg(REG_HEADER, {8'h00, hdr});
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_DELTA, {1'b0, delta});
		write_reg(REG_WIDTH, {1'b0, width});
		hdr_now = hdr;
	endtask

	initial begin
		int target;
		int pick;
		logic [SFR_BYTE_W-1:0] strat;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_BYTE;
		in_ch.rx_byte = '0;
		in_ch.live_offset = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HEADER;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset config: stray byte, frames, repeats, bad checksum, bad strategy
		idling = 1'b1;
		push_word(CMD_BYTE, 8'h00, 16'sh0000);
		strays_sent++;
		send_frame({6'b0, ST_LEFT}, 1'b1, 16'sh7FFF);
		send_frame({6'b0, ST_LEFT}, 1'b1, 16'sh0000);
		send_frame({6'b0, ST_RIGHT}, 1'b0, 16'sh1234);
		send_frame(8'h04, 1'b1, 16'sh0000);
		send_frame(8'hFF, 1'b1, 16'sh0000);

		// saturating offsets and an immediate timeout
		configure(8'h00, 16'd0, 15'h7FFF, 15'd0);
		send_frame({6'b0, ST_NONE}, 1'b1, 16'sh0000);
		send_frame({6'b0, ST_LEFT}, 1'b1, 16'sh8000);
		send_frame({6'b0, ST_RIGHT}, 1'b1, 16'sh0000);
		push_word(CMD_TICK, 8'hFF, 16'shFFFF);
		push_word(CMD_TICK, 8'h00, 16'sh0000);

		// clamping to the track
		configure(8'hFF, 16'hFFFF, 15'h4000, 15'h7FFF);
		send_frame({6'b0, ST_STRAIGHT}, 1'b1, -16'sd5);
		send_frame({6'b0, ST_RIGHT}, 1'b1, 16'sh0000);

		// header register changed between strategy and checksum
		push_word(CMD_BYTE, hdr_now, live_rnd());
		push_word(CMD_BYTE, {6'b0, ST_LEFT}, live_rnd());
		settle();
		write_reg(REG_HEADER, 16'h005A);
		hdr_now = 8'h5A;
		push_word(CMD_BYTE, 8'h5A ^ {6'b0, ST_LEFT}, live_rnd());
		frames_sent++;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(8'($urandom), 16'($urandom_range(2, 30)), 15'($urandom), 15'd0);
				1: configure(8'h00, 16'd0, 15'h7FFF, 15'h7FFF);
				2: configure(8'hFF, 16'($urandom_range(1, 10)), 15'($urandom_range(0, 200)),
					15'($urandom_range(1, 400)));
				3: configure(8'($urandom), 16'hFFFF, 15'd0, 15'd1);
				4: configure(8'($urandom), 16'($urandom_range(0, 20)), 15'($urandom),
					15'($urandom));
				default: configure(8'($urandom), 16'd5, 15'($urandom), 15'd0);
			endcase
			idling = (ph != 5);
			if (ph == 2) hold_req = 1'b1;
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					strat = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(4, 255))
						: 8'($urandom_range(0, 3));
					send_frame(strat, $urandom_range(0, 9) != 0, live_rnd());
				end else if (pick < 85) begin
					repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
							: $urandom_range(1, 4))
						push_word(CMD_TICK, 8'($urandom), live_rnd());
				end else begin
					push_word(CMD_BYTE, ($urandom_range(0, 3) == 0) ? hdr_now : 8'($urandom),
						live_rnd());
					strays_sent++;
				end
			end
		end

		settle();
		repeat (6) @(negedge clk);
		$display("run covered %0d words: %0d frames offered, %0d ticks, %0d stray bytes",
			words_sent, frames_sent, ticks_sent, strays_sent);
		$display("accepted %0d frames, %0d offset writes, %0d fallbacks to none",
			frames_ok, offset_writes, timeouts);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sfr_pkg.sv
hdl/sfr_in_if.sv
hdl/sfr_out_if.sv
hdl/sfr_front.sv
hdl/sfr_queue.sv
hdl/sfr_back.sv
hdl/strategy_frame_receiver.sv
tb/sfr_checker.sv
tb/tb.sv
